@@ sv/qifd_pkg.sv @@
// Package: shared types, register indexes and the bucket-centre phase table.
package qifd_pkg;

  localparam int unsigned CodeW  = 5;
  localparam int unsigned GainW  = 8;
  localparam int unsigned PedW   = 6;
  localparam int unsigned PhaseW = 16;
  localparam int unsigned StepW  = 8;
  localparam int unsigned OutW   = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam int signed OutLow    = -20;
  localparam int signed OutHigh   = 43;
  localparam int signed PedOffset = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN     = 2'd0,
    CFG_PEDESTAL = 2'd1,
    CFG_POLARITY = 2'd2
  } cfg_idx_e;

  // Registered input item.
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] cur_code;
    logic [CodeW-1:0] prev_code;
    logic             cur_q_fine;
  } item_t;

  // Rounded phase step handed to the scaling stage.
  typedef struct packed {
    logic                    valid;
    logic signed [StepW-1:0] step;
  } step_t;

  // atan2 of the bucket centres in 1/65536 turn. Row 0 is the I-fine
  // mapping and row 1 the Q-fine mapping, indexed by the 5-bit code.
  localparam logic signed [PhaseW-1:0] PhaseRom [2][32] = '{
    '{ 16'sd11564,  16'sd14672, -16'sd14677, -16'sd11576,
        16'sd6127,  16'sd11553, -16'sd11564,  -16'sd6164,
        16'sd3960,   16'sd9139,  -16'sd9152,  -16'sd3989,
        16'sd2895,   16'sd7390,  -16'sd7404,  -16'sd2917,
       16'sd29879,  16'sd25389, -16'sd25376, -16'sd29858,
       16'sd28819,  16'sd23645, -16'sd23632, -16'sd28791,
       16'sd26666,  16'sd21236, -16'sd21225, -16'sd26629,
       16'sd21269,  16'sd18122, -16'sd18118, -16'sd21236 },
    '{  16'sd4820,  16'sd10257,  16'sd12424,  16'sd13489,
      -16'sd13495, -16'sd12435, -16'sd10282,  -16'sd4885,
        16'sd1712,   16'sd4831,   16'sd7245,   16'sd8994,
       -16'sd9005,  -16'sd7261,  -16'sd4852,  -16'sd1738,
       16'sd31061,  16'sd27948,  16'sd25536,  16'sd23788,
      -16'sd23776, -16'sd25520, -16'sd27927, -16'sd31034,
       16'sd27960,  16'sd22548,  16'sd20373,  16'sd19301,
      -16'sd19294, -16'sd20361, -16'sd22523, -16'sd27916 }
  };

endpackage

@@ sv/quantized_iq_fm_discriminator.sv @@
// Top level: quantized IQ FM phase-step discriminator with configuration registers.
//
//   Channel  Handshake                     Payload
//   -------  ----------------------------  ---------------------------------------
//   input    start_i, busy_o               current_code_i, previous_code_i,
//                                          current_q_fine_i
//   result   done_o (one-cycle strobe)     contribution_o
//   config   cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item is taken every clock cycle; busy_o stays low. An item is captured
// in the input register, turned into a rounded phase step in the phase-stage
// register and scaled into the result register; done_o is high while that
// result is held there. The three register stages are the input, phase and
// scale registers. Reset clears the valid flags and loads the register
// defaults (gain 1, pedestal 20, normal polarity). The receiver cannot stall
// the block, so results simply flow out one per accepted item.
module quantized_iq_fm_discriminator
  import qifd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [CodeW-1:0]       current_code_i,
  input  logic [CodeW-1:0]       previous_code_i,
  input  logic                   current_q_fine_i,
  output logic                   done_o,
  output logic signed [OutW-1:0] contribution_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  logic [GainW-1:0] gain_q;
  logic [PedW-1:0]  pedestal_q;
  logic             polarity_q;
  logic             in_valid_q;
  logic [CodeW-1:0] cur_code_q;
  logic [CodeW-1:0] prev_code_q;
  logic             cur_q_fine_q;
  item_t            item;
  step_t            step;

  // Every cycle is open to a new transfer on both the input and config sides.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers. Index three is not decoded and is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GainW'(1);
      pedestal_q <= PedW'(PedOffset);
      polarity_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN:     gain_q     <= cfg_data_i[GainW-1:0];
        CFG_PEDESTAL: pedestal_q <= cfg_data_i[PedW-1:0];
        CFG_POLARITY: polarity_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input register: the valid flag is control, the codes are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_code_q   <= current_code_i;
    prev_code_q  <= previous_code_i;
    cur_q_fine_q <= current_q_fine_i;
  end

  always_comb begin
    item.valid      = in_valid_q;
    item.cur_code   = cur_code_q;
    item.prev_code  = prev_code_q;
    item.cur_q_fine = cur_q_fine_q;
  end

  qifd_phase_stage u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .step_o (step)
  );

  qifd_scale_stage u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .gain_i     (gain_q),
    .pedestal_i (pedestal_q),
    .polarity_i (polarity_q),
    .valid_o    (done_o),
    .value_o    (contribution_o)
  );

endmodule

@@ sv/qifd_phase_stage.sv @@
// Phase stage: table lookup, wrapped phase difference and rounding to 1/256 turn.
module qifd_phase_stage
  import qifd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  output step_t step_o
);

  logic signed [PhaseW-1:0] cur_phase;
  logic signed [PhaseW-1:0] prev_phase;
  logic [PhaseW-1:0]        diff_ob;
  logic [StepW-1:0]         whole;
  logic [StepW-1:0]         frac;
  logic                     round_up;
  logic [StepW:0]           rounded;
  logic signed [StepW-1:0]  step_d;
  logic                     valid_q;
  logic signed [StepW-1:0]  step_q;

  always_comb begin
    cur_phase  = PhaseRom[item_i.cur_q_fine][item_i.cur_code];
    prev_phase = PhaseRom[~item_i.cur_q_fine][item_i.prev_code];
    // Offset-binary form of the wrapped difference: flip the sign bit.
    diff_ob = PhaseW'(cur_phase - prev_phase) ^ {1'b1, {(PhaseW-1){1'b0}}};
    whole   = diff_ob[PhaseW-1 -: StepW];
    frac    = diff_ob[StepW-1:0];
    // Round to nearest, ties to even.
    round_up = (frac > 8'd128) || ((frac == 8'd128) && whole[0]);
    rounded  = {1'b0, whole} + {{StepW{1'b0}}, round_up};
    // Only +128 can overflow; it saturates to +127.
    if (rounded[StepW]) begin
      step_d = 8'sd127;
    end else begin
      step_d = $signed({~rounded[StepW-1], rounded[StepW-2:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  assign step_o.valid = valid_q;
  assign step_o.step  = step_q;

endmodule

@@ sv/qifd_scale_stage.sv @@
// Scale stage: polarity, gain multiply, pedestal offset and output saturation.
module qifd_scale_stage
  import qifd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  step_t                  step_i,
  input  logic [GainW-1:0]       gain_i,
  input  logic [PedW-1:0]        pedestal_i,
  input  logic                   polarity_i,
  output logic                   valid_o,
  output logic signed [OutW-1:0] value_o
);

  localparam int unsigned ProdW = 18;

  logic signed [StepW:0]   step_pol;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] sum;
  logic signed [OutW-1:0]  value_d;
  logic                    valid_q;
  logic signed [OutW-1:0]  value_q;

  always_comb begin
    step_pol = polarity_i ? -(StepW+1)'(step_i.step) : (StepW+1)'(step_i.step);
    prod = ProdW'(step_pol) * $signed({{(ProdW-GainW){1'b0}}, gain_i});
    sum  = prod + $signed({{(ProdW-PedW){1'b0}}, pedestal_i}) - ProdW'(PedOffset);
    if (sum < ProdW'(OutLow)) begin
      value_d = OutW'(OutLow);
    end else if (sum > ProdW'(OutHigh)) begin
      value_d = OutW'(OutHigh);
    end else begin
      value_d = sum[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= step_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

@@ sv/qifd_checker.sv @@
// Checker: port-level properties of the discriminator, bound to the top level.
module qifd_checker
  import qifd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic signed [OutW-1:0] contribution_o
);

  // Results always land inside the saturation window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((contribution_o >= OutW'(OutLow)) && (contribution_o <= OutW'(OutHigh))))
    else $error("contribution outside saturation range");

  // Every result strobe traces back to a matching input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && rst_ni, 3))
    else $error("result strobe without matching input transfer");

  // Every transfer yields its result when reset stays off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start_i && !busy_o && rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1))
      |-> done_o)
    else $error("input transfer produced no result");

  // The block takes a new item in every cycle out of reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> !busy_o)
    else $error("busy raised; back-to-back flow broken");

endmodule

bind quantized_iq_fm_discriminator qifd_checker u_qifd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .contribution_o (contribution_o)
);
